@@ sv/pczt_pkg.sv @@
// Shared constants, microcode word type and control store for the print column tracker.
package pczt_pkg;

  localparam int COLUMN_BITS_DEF = 8;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_MARGIN = 2'd0;
  localparam logic [1:0] REG_ZW     = 2'd1;
  localparam logic [1:0] REG_ZT     = 2'd2;

  localparam logic [7:0] MARGIN_RESET = 8'd72;
  localparam logic [5:0] ZW_RESET     = 6'd15;
  localparam logic [3:0] ZT_RESET     = 4'd5;
  localparam logic [7:0] MIN_MARGIN   = 8'd16;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_NL    = 8'd10;

  // request kinds
  localparam logic [2:0] REQ_ITEM  = 3'd0;
  localparam logic [2:0] REQ_COMMA = 3'd1;
  localparam logic [2:0] REQ_TAB   = 3'd2;
  localparam logic [2:0] REQ_SPC   = 3'd3;
  localparam logic [2:0] REQ_NL    = 3'd4;

  // guard conditions
  localparam logic [2:0] C_ALWAYS    = 3'd0;
  localparam logic [2:0] C_WRAP_ITEM = 3'd1;
  localparam logic [2:0] C_COL_GE_M  = 3'd2;
  localparam logic [2:0] C_DIV_BUSY  = 3'd3;
  localparam logic [2:0] C_COMMA_NL  = 3'd4;
  localparam logic [2:0] C_AMT_ZERO  = 3'd5;
  localparam logic [2:0] C_COL_GT_T  = 3'd6;
  localparam logic [2:0] C_CNT_ZERO  = 3'd7;

  // result emitted by a step
  localparam logic [2:0] E_NONE  = 3'd0;
  localparam logic [2:0] E_NL    = 3'd1;
  localparam logic [2:0] E_CHAR  = 3'd2;
  localparam logic [2:0] E_SPACE = 3'd3;
  localparam logic [2:0] E_ERR   = 3'd4;

  // datapath operations
  localparam logic [2:0] O_NONE      = 3'd0;
  localparam logic [2:0] O_DIV_COMMA = 3'd1;
  localparam logic [2:0] O_DIV_TAB   = 3'd2;
  localparam logic [2:0] O_CNT_AMT   = 3'd3;
  localparam logic [2:0] O_CNT_COMMA = 3'd4;
  localparam logic [2:0] O_TGT       = 3'd5;
  localparam logic [2:0] O_CNT_TAB   = 3'd6;

  // tlast selection
  localparam logic [1:0] L_NEVER    = 2'd0;
  localparam logic [1:0] L_ALWAYS   = 2'd1;
  localparam logic [1:0] L_RUN_ALL  = 2'd2;
  localparam logic [1:0] L_TGT_ZERO = 2'd3;

  // sequencing
  localparam logic [1:0] J_NEXT    = 2'd0;
  localparam logic [1:0] J_GOTO_IF = 2'd1;
  localparam logic [1:0] J_END_IF  = 2'd2;
  localparam logic [1:0] J_END     = 2'd3;

  localparam int PC_BITS  = 5;
  localparam int PROG_LEN = 18;

  localparam logic [PC_BITS-1:0] PC_ITEM   = 5'd0;
  localparam logic [PC_BITS-1:0] PC_COMMA  = 5'd3;
  localparam logic [PC_BITS-1:0] PC_CWAIT  = 5'd4;
  localparam logic [PC_BITS-1:0] PC_TAB    = 5'd7;
  localparam logic [PC_BITS-1:0] PC_TWAIT  = 5'd9;
  localparam logic [PC_BITS-1:0] PC_SPC    = 5'd13;
  localparam logic [PC_BITS-1:0] PC_NL     = 5'd14;
  localparam logic [PC_BITS-1:0] PC_SPLOOP = 5'd15;

  typedef struct packed {
    logic [2:0]         guard;
    logic [2:0]         emit;
    logic [2:0]         op;
    logic [1:0]         last_sel;
    logic [1:0]         jump;
    logic [PC_BITS-1:0] target;
  } uword_t;

  function automatic uword_t mk(input logic [2:0] g, input logic [2:0] e,
                                input logic [2:0] o, input logic [1:0] l,
                                input logic [1:0] j, input logic [PC_BITS-1:0] t);
    uword_t w;
    w.guard    = g;
    w.emit     = e;
    w.op       = o;
    w.last_sel = l;
    w.jump     = j;
    w.target   = t;
    return w;
  endfunction

  function automatic uword_t ucode_rom(input logic [PC_BITS-1:0] pc);
    uword_t w;
    case (pc)
      // item character: optional wrap before the item, wrap at margin, then the char
      5'd0:  w = mk(C_WRAP_ITEM, E_NL,   O_NONE,      L_NEVER,    J_NEXT,    PC_ITEM);
      5'd1:  w = mk(C_COL_GE_M,  E_NL,   O_NONE,      L_NEVER,    J_NEXT,    PC_ITEM);
      5'd2:  w = mk(C_ALWAYS,    E_CHAR, O_NONE,      L_ALWAYS,   J_END,     PC_ITEM);
      // comma
      5'd3:  w = mk(C_ALWAYS,    E_NONE, O_DIV_COMMA, L_NEVER,    J_NEXT,    PC_ITEM);
      5'd4:  w = mk(C_DIV_BUSY,  E_NONE, O_NONE,      L_NEVER,    J_GOTO_IF, PC_CWAIT);
      5'd5:  w = mk(C_COMMA_NL,  E_NL,   O_NONE,      L_ALWAYS,   J_END_IF,  PC_ITEM);
      5'd6:  w = mk(C_ALWAYS,    E_NONE, O_CNT_COMMA, L_NEVER,    J_GOTO_IF, PC_SPLOOP);
      // tab
      5'd7:  w = mk(C_AMT_ZERO,  E_ERR,  O_NONE,      L_ALWAYS,   J_END_IF,  PC_ITEM);
      5'd8:  w = mk(C_ALWAYS,    E_NONE, O_DIV_TAB,   L_NEVER,    J_NEXT,    PC_ITEM);
      5'd9:  w = mk(C_DIV_BUSY,  E_NONE, O_NONE,      L_NEVER,    J_GOTO_IF, PC_TWAIT);
      5'd10: w = mk(C_ALWAYS,    E_NONE, O_TGT,       L_NEVER,    J_NEXT,    PC_ITEM);
      5'd11: w = mk(C_COL_GT_T,  E_NL,   O_NONE,      L_TGT_ZERO, J_NEXT,    PC_ITEM);
      5'd12: w = mk(C_ALWAYS,    E_NONE, O_CNT_TAB,   L_NEVER,    J_GOTO_IF, PC_SPLOOP);
      // spc
      5'd13: w = mk(C_ALWAYS,    E_NONE, O_CNT_AMT,   L_NEVER,    J_GOTO_IF, PC_SPLOOP);
      // newline
      5'd14: w = mk(C_ALWAYS,    E_NL,   O_NONE,      L_ALWAYS,   J_END,     PC_ITEM);
      // space run loop
      5'd15: w = mk(C_CNT_ZERO,  E_NONE, O_NONE,      L_NEVER,    J_END_IF,  PC_ITEM);
      5'd16: w = mk(C_COL_GE_M,  E_NL,   O_NONE,      L_NEVER,    J_NEXT,    PC_ITEM);
      5'd17: w = mk(C_ALWAYS,    E_SPACE, O_NONE,     L_RUN_ALL,  J_GOTO_IF, PC_SPLOOP);
      default: w = mk(C_ALWAYS,  E_NONE, O_NONE,      L_NEVER,    J_END,     PC_ITEM);
    endcase
    return w;
  endfunction

  function automatic logic [PC_BITS-1:0] entry_pc(input logic [2:0] req);
    logic [PC_BITS-1:0] e;
    unique case (req)
      REQ_ITEM:  e = PC_ITEM;
      REQ_COMMA: e = PC_COMMA;
      REQ_TAB:   e = PC_TAB;
      REQ_SPC:   e = PC_SPC;
      default:   e = PC_NL;
    endcase
    return e;
  endfunction

endpackage

@@ sv/pczt_rem.sv @@
// Restoring remainder unit, one dividend bit per cycle.
module pczt_rem #(
  parameter int DVD_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [7:0]          divisor,
  output logic                busy,
  output logic [7:0]          rem
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic [DVD_BITS-1:0] dvd;
  logic [7:0]          dsr;
  logic [CNT_BITS-1:0] count;
  logic [8:0]          trial;
  logic                ge;
  logic [7:0]          rem_next;

  assign trial    = {rem, dvd[DVD_BITS-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign rem_next = ge ? 8'(trial - {1'b0, dsr}) : trial[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && count == CNT_BITS'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd   <= dividend;
      dsr   <= divisor;
      rem   <= 8'd0;
      count <= CNT_BITS'(DVD_BITS);
    end else if (busy) begin
      dvd   <= dvd << 1;
      rem   <= rem_next;
      count <= count - CNT_BITS'(1);
    end
  end

endmodule

@@ sv/print_column_zone_tracker.sv @@
// Print column tracker: microcoded sequencer over a column/count datapath.
// One control step per cycle, unless a held result stalls the step that emits; a request is
// accepted while idle, before its first step. Item char: wrap before the item, wrap at margin,
// then the char. Spc runs the space loop. Comma and tab wait on the remainder unit, which works
// over max(COLUMN_BITS,8) dividend bits; a tab with zero amount gives an error result instead.
// Reset (rst, synchronous): column 0, margin 72, zone width 15, zones 5, idle.
module print_column_zone_tracker #(
  parameter int COLUMN_BITS = pczt_pkg::COLUMN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code, item_len, amount
  input  logic [3:0]  s_axis_tuser,  // req_type, item_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_char, repeat_res
  output logic [0:0]  m_axis_tuser,  // tab_error
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DW = (COLUMN_BITS > 8) ? COLUMN_BITS : 8;
  localparam int W  = DW + 1;
  // zone limit compare width, wide enough for both sides
  localparam int CW = (W > 10) ? W : 10;

  // configuration
  logic [7:0] line_margin;
  logic [5:0] zone_width;
  logic [3:0] zone_total;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_margin <= pczt_pkg::MARGIN_RESET;
      zone_width  <= pczt_pkg::ZW_RESET;
      zone_total  <= pczt_pkg::ZT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        pczt_pkg::REG_MARGIN: line_margin <= pwdata[7:0];
        pczt_pkg::REG_ZW:     zone_width  <= pwdata[5:0];
        pczt_pkg::REG_ZT:     zone_total  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pczt_pkg::REG_MARGIN: prdata = {24'd0, line_margin};
      pczt_pkg::REG_ZW:     prdata = {26'd0, zone_width};
      pczt_pkg::REG_ZT:     prdata = {28'd0, zone_total};
      default:              prdata = 32'd0;
    endcase
  end

  // sequencer and datapath state
  logic                         busy;
  logic [pczt_pkg::PC_BITS-1:0] pc;
  logic [COLUMN_BITS-1:0]       column;
  logic [7:0]                   cnt;
  logic [7:0]                   tgt;
  logic [7:0]                   in_char;
  logic                         in_start;
  logic [7:0]                   in_len;
  logic [7:0]                   in_amount;

  pczt_pkg::uword_t uw;
  logic             g;
  logic             emit_go;
  logic             stall;
  logic             adv;
  logic             out_free;
  logic             in_go;

  logic [7:0]   m_eff;
  logic [5:0]   zw_eff;
  logic [W-1:0] col_w;
  logic [W-1:0] m_w;
  logic [W-1:0] next_w;
  logic [9:0]   limit;
  logic         comma_nl;
  logic [7:0]   room;
  logic [7:0]   run;

  logic         div_start;
  logic         div_busy;
  logic [7:0]   div_rem;
  logic [DW-1:0] div_dvd;
  logic [7:0]   div_dsr;

  assign uw = pczt_pkg::ucode_rom(pc);

  assign m_eff  = (line_margin < pczt_pkg::MIN_MARGIN) ? pczt_pkg::MIN_MARGIN : line_margin;
  assign zw_eff = (zone_width == 6'd0) ? 6'd1 : zone_width;
  assign col_w  = W'(column);
  assign m_w    = W'(m_eff);

  // next zone start = column rounded down to a zone, plus one zone
  assign next_w   = col_w - W'(div_rem) + W'(zw_eff);
  assign limit    = 10'(zone_total - 4'd1) * 10'(zw_eff);
  assign comma_nl = (zone_total == 4'd0) || (CW'(next_w) > CW'(limit)) || (next_w > m_w);

  assign room = 8'(m_w - col_w);
  assign run  = (room < cnt) ? room : cnt;

  always_comb begin
    case (uw.guard)
      pczt_pkg::C_ALWAYS:    g = 1'b1;
      pczt_pkg::C_WRAP_ITEM: g = in_start && (column != '0) && (col_w + W'(in_len) > m_w);
      pczt_pkg::C_COL_GE_M:  g = col_w >= m_w;
      pczt_pkg::C_DIV_BUSY:  g = div_busy;
      pczt_pkg::C_COMMA_NL:  g = comma_nl;
      pczt_pkg::C_AMT_ZERO:  g = in_amount == 8'd0;
      pczt_pkg::C_COL_GT_T:  g = col_w > W'(tgt);
      default:               g = cnt == 8'd0;
    endcase
  end

  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign emit_go  = busy && g && (uw.emit != pczt_pkg::E_NONE);
  assign stall    = emit_go && !out_free;
  assign adv      = busy && !stall;
  assign in_go    = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !busy;

  // remainder unit: column mod zone width for comma, (amount-1) mod margin for tab
  assign div_start = adv && g && (uw.op == pczt_pkg::O_DIV_COMMA || uw.op == pczt_pkg::O_DIV_TAB);
  assign div_dvd   = (uw.op == pczt_pkg::O_DIV_TAB) ? DW'(in_amount - 8'd1) : DW'(column);
  assign div_dsr   = (uw.op == pczt_pkg::O_DIV_TAB) ? m_eff : {2'b00, zw_eff};

  pczt_rem #(.DVD_BITS(DW)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= pczt_pkg::PC_ITEM;
    end else if (!busy) begin
      if (in_go && s_axis_tuser[2:0] <= pczt_pkg::REQ_NL) begin
        busy <= 1'b1;
        pc   <= pczt_pkg::entry_pc(s_axis_tuser[2:0]);
      end
    end else if (adv) begin
      unique case (uw.jump)
        pczt_pkg::J_NEXT:    pc <= pc + 1'b1;
        pczt_pkg::J_GOTO_IF: pc <= g ? uw.target : pc + 1'b1;
        pczt_pkg::J_END_IF: begin
          if (g) busy <= 1'b0;
          else pc <= pc + 1'b1;
        end
        default:             busy <= 1'b0;
      endcase
    end
  end

  // column
  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (adv && g) begin
      case (uw.emit)
        pczt_pkg::E_NL:    column <= '0;
        pczt_pkg::E_CHAR:  column <= COLUMN_BITS'(col_w + W'(1));
        pczt_pkg::E_SPACE: column <= COLUMN_BITS'(col_w + W'(run));
        default: ;
      endcase
    end
  end

  // input latch, count and tab target
  always_ff @(posedge clk) begin
    if (in_go) begin
      in_char   <= s_axis_tdata[7:0];
      in_len    <= s_axis_tdata[15:8];
      in_amount <= s_axis_tdata[23:16];
      in_start  <= s_axis_tuser[3];
    end
    if (adv && g) begin
      case (uw.op)
        pczt_pkg::O_CNT_AMT:   cnt <= in_amount;
        pczt_pkg::O_CNT_COMMA: cnt <= 8'(zw_eff - div_rem[5:0]);
        pczt_pkg::O_TGT:       tgt <= div_rem;
        pczt_pkg::O_CNT_TAB:   cnt <= 8'(W'(tgt) - col_w);
        default: ;
      endcase
      if (uw.emit == pczt_pkg::E_SPACE) cnt <= cnt - run;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_go && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go && out_free) begin
      case (uw.emit)
        pczt_pkg::E_NL: begin
          m_axis_tdata <= {8'd1, pczt_pkg::CH_NL};
          m_axis_tuser <= 1'b0;
        end
        pczt_pkg::E_CHAR: begin
          m_axis_tdata <= {8'd1, in_char};
          m_axis_tuser <= 1'b0;
        end
        pczt_pkg::E_SPACE: begin
          m_axis_tdata <= {run, pczt_pkg::CH_SPACE};
          m_axis_tuser <= 1'b0;
        end
        default: begin
          m_axis_tdata <= 16'd0;
          m_axis_tuser <= 1'b1;
        end
      endcase
      case (uw.last_sel)
        pczt_pkg::L_NEVER:   m_axis_tlast <= 1'b0;
        pczt_pkg::L_ALWAYS:  m_axis_tlast <= 1'b1;
        pczt_pkg::L_RUN_ALL: m_axis_tlast <= run == cnt;
        default:             m_axis_tlast <= tgt == 8'd0;
      endcase
    end
  end

  // the sequencer never leaves a division running behind it
  a_div_idle: assert property (@(posedge clk) disable iff (rst) !busy |-> !div_busy)
    else $error("remainder unit busy while sequencer idle");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[15:8] == 8'd0 && m_axis_tlast)
    else $error("tab error result malformed");

  a_rep_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[15:8] != 8'd0)
    else $error("empty run emitted");

  a_nl_clears: assert property (@(posedge clk) disable iff (rst)
    adv && g && uw.emit == pczt_pkg::E_NL |=> column == '0)
    else $error("column not cleared after newline");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc < pczt_pkg::PC_BITS'(pczt_pkg::PROG_LEN))
    else $error("step counter outside program");

endmodule

@@ tb/tb_print_column_zone_tracker.sv @@
// Self-checking testbench for the print column zone tracker: stream stimulus, APB setup, run checks.
`timescale 1ns / 100ps

module tb_print_column_zone_tracker;

  localparam int          CYCLE_LIMIT = 600000;
  localparam int          STALL_LEN   = 300;
  localparam int          SETTLE_CYC  = 100;
  localparam logic [2:0]  REQ_BAD_LO  = 3'd5;
  localparam logic [2:0]  REQ_BAD_HI  = 3'd7;

  typedef struct packed {
    logic [2:0] req;
    logic [7:0] ch;
    logic       start;
    logic [7:0] len;
    logic [7:0] amt;
  } print_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] rep;
    logic       err;
    logic       last;
  } char_run_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;   // char_code, item_len, amount
  logic [3:0]  s_axis_tuser = '0;   // req_type, item_start
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // out_char, repeat_res
  logic [0:0]  m_axis_tuser;        // tab_error
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  print_column_zone_tracker u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // column tracking model state and its register copies
  logic [7:0]  col_now    = '0;
  logic [7:0]  cfg_margin = pczt_pkg::MARGIN_RESET;
  logic [5:0]  cfg_zw     = pczt_pkg::ZW_RESET;
  logic [3:0]  cfg_zt     = pczt_pkg::ZT_RESET;

  char_run_t   run_expect_q[$];
  print_req_t  req_feed_q[$];
  print_req_t  drv_item;
  char_run_t   got_run;
  char_run_t   exp_run;
  int          err_cnt = 0;
  int          req_cnt = 0;
  int          cyc = 0;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 78;
  int          stall_req_cnt = 0;
  int          stall_ack_cnt = 0;
  int          stall_left = 0;

  function automatic void push_run(logic [7:0] ch, logic [7:0] rep, logic err);
    char_run_t r;
    r.ch   = ch;
    r.rep  = rep;
    r.err  = err;
    r.last = 1'b0;
    run_expect_q.push_back(r);
  endfunction

  function automatic void put_newline();
    push_run(pczt_pkg::CH_NL, 8'd1, 1'b0);
    col_now = '0;
  endfunction

  function automatic void put_spaces(int unsigned count, int unsigned m);
    int unsigned run;
    while (count > 0) begin
      if (32'(col_now) >= m) put_newline();
      run = m - 32'(col_now);
      if (run > count) run = count;
      push_run(pczt_pkg::CH_SPACE, run[7:0], 1'b0);
      col_now = col_now + run[7:0];
      count -= run;
    end
  endfunction

  function automatic void track_print_req(print_req_t rq);
    int unsigned m;
    int unsigned zw;
    int unsigned nxt;
    int unsigned n;
    int          lim;
    int          base;
    m    = 32'((cfg_margin < pczt_pkg::MIN_MARGIN) ? pczt_pkg::MIN_MARGIN : cfg_margin);
    base = run_expect_q.size();
    case (rq.req)
      pczt_pkg::REQ_ITEM: begin
        // an item that would overflow a non-empty line starts afresh
        if (rq.start && col_now > 0 && (int'(col_now) + int'(rq.len)) > int'(m))
          put_newline();
        if (32'(col_now) >= m) put_newline();
        push_run(rq.ch, 8'd1, 1'b0);
        col_now = col_now + 8'd1;
      end
      pczt_pkg::REQ_COMMA: begin
        zw  = (cfg_zw == 6'd0) ? 32'd1 : 32'(cfg_zw);
        nxt = (32'(col_now) / zw + 1) * zw;
        lim = (int'(cfg_zt) - 1) * int'(zw);
        if (int'(nxt) > lim || nxt > m) put_newline();
        else put_spaces(nxt - 32'(col_now), m);
      end
      pczt_pkg::REQ_TAB: begin
        n = 32'(rq.amt);
        if (n == 0) begin
          push_run(8'd0, 8'd0, 1'b1);
        end else begin
          if (n > m) n = n - m * ((n - 1) / m);
          if (32'(col_now) > n - 1) put_newline();
          if (32'(col_now) < n - 1) put_spaces(n - 1 - 32'(col_now), m);
        end
      end
      pczt_pkg::REQ_SPC: put_spaces(32'(rq.amt), m);
      pczt_pkg::REQ_NL:  put_newline();
      default: ;
    endcase
    if (run_expect_q.size() > base)
      run_expect_q[run_expect_q.size() - 1].last = 1'b1;
  endfunction

  // input stream driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (req_feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = req_feed_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drv_item.amt, drv_item.len, drv_item.ch};
        s_axis_tuser  <= {drv_item.start, drv_item.req};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_req_cnt != stall_ack_cnt) begin
      m_axis_tready <= 1'b0;
      stall_left    <= STALL_LEN;
      stall_ack_cnt <= stall_ack_cnt + 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check results first, then predict for the transaction accepted at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_run = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tuser[0], m_axis_tlast};
        if (run_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected run char=%0d rep=%0d err=%0b last=%0b", $time,
                   got_run.ch, got_run.rep, got_run.err, got_run.last);
        end else begin
          exp_run = run_expect_q.pop_front();
          if (got_run != exp_run) begin
            err_cnt++;
            $display("%0t: mismatch expected %p got %p", $time, exp_run, got_run);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        track_print_req({s_axis_tuser[2:0], s_axis_tdata[7:0], s_axis_tuser[3],
                         s_axis_tdata[15:8], s_axis_tdata[23:16]});
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("** print_column_zone_tracker: FAILED **");
      $finish;
    end
  end

  task automatic add_req(logic [2:0] req, logic [7:0] ch, logic start, logic [7:0] len,
                         logic [7:0] amt);
    req_feed_q.push_back('{req: req, ch: ch, start: start, len: len, amt: amt});
    if (req <= pczt_pkg::REQ_NL) req_cnt++;
  endtask

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      pczt_pkg::REG_MARGIN: cfg_margin = val[7:0];
      pczt_pkg::REG_ZW:     cfg_zw     = val[5:0];
      pczt_pkg::REG_ZT:     cfg_zt     = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_zones(logic [7:0] margin, logic [5:0] zw, logic [3:0] zt);
    apb_write(pczt_pkg::REG_MARGIN, {24'd0, margin});
    apb_write(pczt_pkg::REG_ZW, {26'd0, zw});
    apb_write(pczt_pkg::REG_ZT, {28'd0, zt});
  endtask

  // hold the sender until every run is back and the block has had time to settle
  task automatic drain();
    do begin
      while (req_feed_q.size() > 0 || s_axis_tvalid || run_expect_q.size() > 0)
        @(posedge clk);
      repeat (SETTLE_CYC) @(posedge clk);
    end while (req_feed_q.size() > 0 || s_axis_tvalid || run_expect_q.size() > 0);
  endtask

  task automatic gen_random(int target);
    int goal;
    int r;
    int wlen;
    goal = req_cnt + target;
    while (req_cnt < goal) begin
      r = int'($urandom_range(99));
      if (r < 45) begin
        wlen = int'(($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 10));
        add_req(pczt_pkg::REQ_ITEM, 8'($urandom_range(255)), 1'b1, wlen[7:0],
                8'($urandom_range(255)));
        for (int i = 1; i < wlen; i++)
          add_req(pczt_pkg::REQ_ITEM, 8'($urandom_range(255)), 1'b0, 8'($urandom_range(255)),
                  8'($urandom_range(255)));
      end else if (r < 57) begin
        add_req(pczt_pkg::REQ_COMMA, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 69) begin
        add_req(pczt_pkg::REQ_TAB, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)),
                ($urandom_range(7) == 0) ? 8'd0 : 8'($urandom_range(255)));
      end else if (r < 79) begin
        add_req(pczt_pkg::REQ_SPC, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)),
                ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(40)));
      end else if (r < 85) begin
        add_req(pczt_pkg::REQ_NL, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      end else if (r < 88) begin
        add_req(3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end else begin
        // stray character with arbitrary start flag and length
        add_req(pczt_pkg::REQ_ITEM, 8'($urandom_range(255)), 1'($urandom_range(1)),
                8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset settings
    add_req(pczt_pkg::REQ_ITEM, 8'd0, 1'b1, 8'd1, 8'd0);
    add_req(pczt_pkg::REQ_ITEM, 8'd255, 1'b1, 8'd255, 8'd255);
    add_req(pczt_pkg::REQ_ITEM, 8'd65, 1'b1, 8'd0, 8'd0);
    repeat (5) add_req(pczt_pkg::REQ_COMMA, 8'd0, 1'b0, 8'd0, 8'd0);
    add_req(pczt_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd0);
    add_req(pczt_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd255);
    add_req(pczt_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd39);
    add_req(pczt_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd5);
    add_req(pczt_pkg::REQ_TAB, 8'd0, 1'b0, 8'd0, 8'd1);
    add_req(pczt_pkg::REQ_SPC, 8'd0, 1'b0, 8'd0, 8'd0);
    add_req(pczt_pkg::REQ_SPC, 8'hff, 1'b1, 8'hff, 8'd255);
    add_req(pczt_pkg::REQ_SPC, 8'd0, 1'b0, 8'd0, 8'd1);
    add_req(pczt_pkg::REQ_NL, 8'd0, 1'b0, 8'd0, 8'd0);
    add_req(pczt_pkg::REQ_ITEM, 8'd90, 1'b1, 8'd100, 8'd0);
    for (int k = REQ_BAD_LO; k <= REQ_BAD_HI; k++)
      add_req(k[2:0], 8'hff, 1'b1, 8'hff, 8'hff);
    add_req(pczt_pkg::REQ_SPC, 8'd0, 1'b0, 8'd0, 8'd70);
    add_req(pczt_pkg::REQ_ITEM, 8'd66, 1'b1, 8'd1, 8'd0);
    add_req(pczt_pkg::REQ_ITEM, 8'd67, 1'b1, 8'd5, 8'd0);
    drain();

    set_zones(8'd16, 6'd1, 4'd8);
    gen_random(45);
    drain();

    // widest line; long receiver hold-off while the sender keeps offering
    set_zones(8'd255, 6'd63, 4'd8);
    gen_random(45);
    stall_req_cnt++;
    add_req(pczt_pkg::REQ_NL, 8'd0, 1'b0, 8'd0, 8'd0);
    add_req(pczt_pkg::REQ_SPC, 8'd0, 1'b0, 8'd0, 8'd150);
    drain();

    // margin drops under the column; zero zone width and zero zones
    send_idle_pct = 78;
    recv_idle_pct = 18;
    set_zones(8'd40, 6'd0, 4'd0);
    gen_random(40);
    drain();

    // zone count beyond the usual range with wide zones
    set_zones(8'd8, 6'd40, 4'd15);
    gen_random(40);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_zones(pczt_pkg::MARGIN_RESET, pczt_pkg::ZW_RESET, pczt_pkg::ZT_RESET);
    gen_random(60);
    drain();

    if (err_cnt == 0) begin
      $display("** print_column_zone_tracker: PASSED **");
    end else begin
      $display("** print_column_zone_tracker: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pczt_pkg.sv
sv/pczt_rem.sv
sv/print_column_zone_tracker.sv
tb/tb_print_column_zone_tracker.sv
